// File: src/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MODE_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int TOL_W          = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_MUL    = 4'd2,
    MODE_CONJ   = 4'd3,
    MODE_MOD    = 4'd4,
    MODE_DIV_RE = 4'd5,
    MODE_DIV_CX = 4'd6,
    MODE_EQ     = 4'd7,
    MODE_NE     = 4'd8
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_SAT      = 2'd2
  } status_t;

endpackage
`default_nettype wire

// File: src/cau_if.sv
// Operand and result stream interfaces of the complex arithmetic unit.
`default_nettype none
interface cau_in_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [cau_pkg::MODE_W-1:0]    mode;
  logic signed [DATA_WIDTH-1:0]  a_re;
  logic signed [DATA_WIDTH-1:0]  a_im;
  logic signed [DATA_WIDTH-1:0]  b_re;
  logic signed [DATA_WIDTH-1:0]  b_im;

  modport source(output valid, mode, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  result_re;
  logic signed [DATA_WIDTH-1:0]  result_im;
  logic                          compare_flag;
  logic [cau_pkg::STATUS_W-1:0]  status;

  modport source(output valid, result_re, result_im, compare_flag, status, input ready);
  modport sink(input valid, result_re, result_im, compare_flag, status, output ready);
endinterface
`default_nettype wire

// File: src/complex_arithmetic_unit_core.sv
// Pipelined complex arithmetic unit: add, sub, mul, conj, modulus, divides, compares.
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      mode, a_re, a_im, b_re, b_im
//  out_chan  out  valid/ready      result_re, result_im, compare_flag, status
//  cfg       in   cfg_we           cfg_wdata (equal tolerance)
//
// One item per cycle while the output is not stalled; items pass through the restoring divider
// (one quotient bit per stage, DATA_WIDTH + 1 stages) that also carries the square root.
// Synchronous active-low reset clears the valid bits and loads the tolerance default.
// All stages advance together whenever the output register is empty or being taken.
`default_nettype none
module complex_arithmetic_unit_core #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  cau_in_if.sink                         in_chan,
  cau_out_if.source                      out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [cau_pkg::TOL_W-1:0] cfg_wdata
);
  import cau_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int SW  = 2 * DW;
  localparam int PW  = 2 * DW + 1;
  localparam int QB  = DW + 1;
  localparam int NW  = PW + FRAC_BITS;
  localparam int RMW = DW + 2;
  localparam int TW  = (DW + 1 > TOL_W) ? DW + 1 : TOL_W;

  typedef struct packed {
    mode_t                 mode;
    logic signed [DW-1:0]  ar;
    logic signed [DW-1:0]  ai;
    logic signed [DW-1:0]  br;
    logic signed [DW-1:0]  bi;
  } a_item_t;

  typedef struct packed {
    mode_t                 mode;
    logic [DW-1:0]         re;
    logic [DW-1:0]         im;
    logic                  flag;
    logic                  sat;
    logic                  dz;
    logic                  dsgn;
    logic signed [DW-1:0]  ar;
    logic signed [DW-1:0]  ai;
    logic signed [DW-1:0]  br;
    logic signed [SW-1:0]  p_rr;
    logic signed [SW-1:0]  p_ii;
    logic signed [SW-1:0]  p_ri;
    logic signed [SW-1:0]  p_ir;
    logic signed [SW-1:0]  sq_ar;
    logic signed [SW-1:0]  sq_ai;
    logic signed [SW-1:0]  sq_br;
    logic signed [SW-1:0]  sq_bi;
  } b_item_t;

  typedef struct packed {
    mode_t                 mode;
    logic [DW-1:0]         re;
    logic [DW-1:0]         im;
    logic                  flag;
    logic                  sat;
    logic                  dz;
    logic                  dsgn;
    logic signed [PW-1:0]  num_re;
    logic signed [PW-1:0]  num_im;
    logic [PW-1:0]         den;
    logic [SW-1:0]         rad;
  } c_item_t;

  typedef struct packed {
    logic [PW-1:0] den;
    logic [PW-1:0] rem;
    logic [QB-1:0] quo;
    logic [QB-1:0] low;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [SW-1:0]  rad;
    logic [RMW-1:0] rem;
    logic [DW-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    mode_t          mode;
    logic [DW-1:0]  re;
    logic [DW-1:0]  im;
    logic           flag;
    logic           sat;
    logic           dz;
    lane_t          l_re;
    lane_t          l_im;
    sqrt_t          sq;
  } d_item_t;

  // {sat, value} for a sum one bit wider than the data
  function automatic logic [DW:0] sat_sum(input logic signed [DW:0] v);
    if (v[DW] != v[DW-1]) return {1'b1, v[DW], {(DW-1){~v[DW]}}};
    return {1'b0, v[DW-1:0]};
  endfunction

  // {sat, value} for sign and magnitude
  function automatic logic [DW:0] clamp(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [PW-1:0] m;
    logic          sat;
    lim = neg ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
    sat = mag > lim;
    m   = sat ? lim : mag;
    if (neg) m = -m;
    return {sat, m[DW-1:0]};
  endfunction

  function automatic logic [PW-1:0] mag_of(input logic signed [PW-1:0] v);
    return v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  function automatic logic signed [PW-1:0] ext_p(input logic signed [SW-1:0] p);
    return {p[SW-1], p};
  endfunction

  function automatic lane_t div_init(input logic neg, input logic [PW-1:0] mag,
                                     input logic [PW-1:0] den);
    lane_t         l;
    logic [NW-1:0] nv;
    logic [NW-1:0] hi;
    nv    = NW'(mag) << FRAC_BITS;
    hi    = nv >> QB;
    l.den = den;
    l.rem = hi[PW-1:0];
    l.quo = '0;
    l.low = nv[QB-1:0];
    l.ovf = hi >= NW'(den);
    l.neg = neg;
    return l;
  endfunction

  function automatic lane_t div_step(input lane_t l);
    lane_t     n;
    logic [PW:0] rr;
    n     = l;
    rr    = {l.rem, l.low[QB-1]};
    n.low = l.low << 1;
    if (rr >= {1'b0, l.den}) begin
      rr    = rr - {1'b0, l.den};
      n.quo = {l.quo[QB-2:0], 1'b1};
    end else begin
      n.quo = {l.quo[QB-2:0], 1'b0};
    end
    n.rem = rr[PW-1:0];
    return n;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t q);
    sqrt_t          n;
    logic [RMW+1:0] rr;
    logic [RMW+1:0] trial;
    n     = q;
    rr    = {q.rem, q.rad[SW-1:SW-2]};
    trial = (RMW + 2)'({q.root, 2'b01});
    n.rad = q.rad << 2;
    if (rr >= trial) begin
      rr     = rr - trial;
      n.root = {q.root[DW-2:0], 1'b1};
    end else begin
      n.root = {q.root[DW-2:0], 1'b0};
    end
    n.rem = rr[RMW-1:0];
    return n;
  endfunction

  logic [TOL_W-1:0] tol_r;
  logic             adv;

  a_item_t a_r;
  logic    av_r;
  b_item_t b_r, b_nxt;
  logic    bv_r;
  c_item_t c_r, c_nxt;
  logic    cv_r;
  d_item_t dv_r   [QB+1];
  d_item_t dv_nxt [QB+1];
  logic [QB:0] dvv_r;

  logic [DW-1:0]       ore_r, ore_nxt;
  logic [DW-1:0]       oim_r, oim_nxt;
  logic                oflag_r, oflag_nxt;
  logic [STATUS_W-1:0] ostat_r, ostat_nxt;
  logic                ov_r;

  assign adv           = !ov_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // stage B: products, simple ops, compares, divide-by-zero checks
  always_comb begin
    logic signed [DW:0] s_re;
    logic signed [DW:0] s_im;
    logic [DW:0]        r_re;
    logic [DW:0]        r_im;
    logic [DW:0]        m_re;
    logic [DW:0]        m_im;
    logic               eq;
    b_nxt       = '0;
    b_nxt.mode  = a_r.mode;
    b_nxt.ar    = a_r.ar;
    b_nxt.ai    = a_r.ai;
    b_nxt.br    = a_r.br;
    b_nxt.p_rr  = a_r.ar * a_r.br;
    b_nxt.p_ii  = a_r.ai * a_r.bi;
    b_nxt.p_ri  = a_r.ar * a_r.bi;
    b_nxt.p_ir  = a_r.ai * a_r.br;
    b_nxt.sq_ar = a_r.ar * a_r.ar;
    b_nxt.sq_ai = a_r.ai * a_r.ai;
    b_nxt.sq_br = a_r.br * a_r.br;
    b_nxt.sq_bi = a_r.bi * a_r.bi;
    b_nxt.dsgn  = a_r.br[DW-1];
    s_re = '0;
    s_im = '0;
    r_re = '0;
    r_im = '0;
    m_re = '0;
    m_im = '0;
    eq   = 1'b0;
    unique case (a_r.mode)
      MODE_ADD, MODE_SUB: begin
        if (a_r.mode == MODE_ADD) begin
          s_re = {a_r.ar[DW-1], a_r.ar} + {a_r.br[DW-1], a_r.br};
          s_im = {a_r.ai[DW-1], a_r.ai} + {a_r.bi[DW-1], a_r.bi};
        end else begin
          s_re = {a_r.ar[DW-1], a_r.ar} - {a_r.br[DW-1], a_r.br};
          s_im = {a_r.ai[DW-1], a_r.ai} - {a_r.bi[DW-1], a_r.bi};
        end
        r_re      = sat_sum(s_re);
        r_im      = sat_sum(s_im);
        b_nxt.re  = r_re[DW-1:0];
        b_nxt.im  = r_im[DW-1:0];
        b_nxt.sat = r_re[DW] | r_im[DW];
      end
      MODE_CONJ: begin
        s_im      = -{a_r.ai[DW-1], a_r.ai};
        r_im      = sat_sum(s_im);
        b_nxt.re  = a_r.ar;
        b_nxt.im  = r_im[DW-1:0];
        b_nxt.sat = r_im[DW];
      end
      MODE_DIV_RE: b_nxt.dz = a_r.br == '0;
      MODE_DIV_CX: b_nxt.dz = (a_r.br == '0) && (a_r.bi == '0);
      MODE_EQ, MODE_NE: begin
        s_re = {a_r.ar[DW-1], a_r.ar} - {a_r.br[DW-1], a_r.br};
        s_im = {a_r.ai[DW-1], a_r.ai} - {a_r.bi[DW-1], a_r.bi};
        m_re = s_re[DW] ? (DW + 1)'(-s_re) : (DW + 1)'(s_re);
        m_im = s_im[DW] ? (DW + 1)'(-s_im) : (DW + 1)'(s_im);
        eq   = (TW'(m_re) <= TW'(tol_r)) && (TW'(m_im) <= TW'(tol_r));
        b_nxt.flag = (a_r.mode == MODE_EQ) ? eq : !eq;
      end
      default: ;
    endcase
  end

  // stage C: wide sums and divider operands
  always_comb begin
    c_nxt      = '0;
    c_nxt.mode = b_r.mode;
    c_nxt.re   = b_r.re;
    c_nxt.im   = b_r.im;
    c_nxt.flag = b_r.flag;
    c_nxt.sat  = b_r.sat;
    c_nxt.dz   = b_r.dz;
    c_nxt.dsgn = b_r.dsgn;
    unique case (b_r.mode)
      MODE_MUL: begin
        c_nxt.num_re = ext_p(b_r.p_rr) - ext_p(b_r.p_ii);
        c_nxt.num_im = ext_p(b_r.p_ri) + ext_p(b_r.p_ir);
      end
      MODE_MOD: c_nxt.rad = b_r.sq_ar + b_r.sq_ai;
      MODE_DIV_RE: begin
        c_nxt.num_re = PW'(b_r.ar);
        c_nxt.num_im = PW'(b_r.ai);
        c_nxt.den    = mag_of(PW'(b_r.br));
      end
      MODE_DIV_CX: begin
        c_nxt.num_re = ext_p(b_r.p_rr) + ext_p(b_r.p_ii);
        c_nxt.num_im = ext_p(b_r.p_ir) - ext_p(b_r.p_ri);
        c_nxt.den    = {1'b0, b_r.sq_br} + {1'b0, b_r.sq_bi};
      end
      default: ;
    endcase
  end

  // stage D: rounding for multiply, divider and root setup
  always_comb begin
    logic          n_re;
    logic          n_im;
    logic [PW-1:0] g_re;
    logic [PW-1:0] g_im;
    logic [DW:0]   k_re;
    logic [DW:0]   k_im;
    n_re = c_r.num_re[PW-1];
    n_im = c_r.num_im[PW-1];
    if (c_r.mode == MODE_DIV_RE) begin
      n_re = n_re ^ c_r.dsgn;
      n_im = n_im ^ c_r.dsgn;
    end
    g_re = mag_of(c_r.num_re);
    g_im = mag_of(c_r.num_im);
    k_re = clamp(n_re, (g_re + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    k_im = clamp(n_im, (g_im + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    dv_nxt[0].mode    = c_r.mode;
    dv_nxt[0].flag    = c_r.flag;
    dv_nxt[0].dz      = c_r.dz;
    dv_nxt[0].l_re    = div_init(n_re, g_re, c_r.den);
    dv_nxt[0].l_im    = div_init(n_im, g_im, c_r.den);
    dv_nxt[0].sq.rad  = c_r.rad;
    dv_nxt[0].sq.rem  = '0;
    dv_nxt[0].sq.root = '0;
    if (c_r.mode == MODE_MUL) begin
      dv_nxt[0].re  = k_re[DW-1:0];
      dv_nxt[0].im  = k_im[DW-1:0];
      dv_nxt[0].sat = k_re[DW] | k_im[DW];
    end else begin
      dv_nxt[0].re  = c_r.re;
      dv_nxt[0].im  = c_r.im;
      dv_nxt[0].sat = c_r.sat;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_comb begin
      dv_nxt[k+1]      = dv_r[k];
      dv_nxt[k+1].l_re = div_step(dv_r[k].l_re);
      dv_nxt[k+1].l_im = div_step(dv_r[k].l_im);
      if (k < DW) dv_nxt[k+1].sq = sqrt_step(dv_r[k].sq);
    end
  end

  // final select and saturation
  always_comb begin
    d_item_t     f;
    logic [DW:0] k_re;
    logic [DW:0] k_im;
    logic        sat;
    f         = dv_r[QB];
    ore_nxt   = '0;
    oim_nxt   = '0;
    oflag_nxt = 1'b0;
    sat       = 1'b0;
    k_re      = clamp(f.l_re.neg, PW'({f.l_re.ovf, f.l_re.quo}));
    k_im      = clamp(f.l_im.neg, PW'({f.l_im.ovf, f.l_im.quo}));
    unique case (f.mode)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_CONJ: begin
        ore_nxt = f.re;
        oim_nxt = f.im;
        sat     = f.sat;
      end
      MODE_MOD: begin
        k_re    = clamp(1'b0, PW'(f.sq.root));
        ore_nxt = k_re[DW-1:0];
        sat     = k_re[DW];
      end
      MODE_DIV_RE, MODE_DIV_CX: begin
        if (!f.dz) begin
          ore_nxt = k_re[DW-1:0];
          oim_nxt = k_im[DW-1:0];
          sat     = k_re[DW] | k_im[DW];
        end
      end
      MODE_EQ, MODE_NE: oflag_nxt = f.flag;
      default: ;
    endcase
    if (f.dz)     ostat_nxt = STATUS_DIV_ZERO;
    else if (sat) ostat_nxt = STATUS_SAT;
    else          ostat_nxt = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_r  <= 1'b0;
      bv_r  <= 1'b0;
      cv_r  <= 1'b0;
      dvv_r <= '0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      av_r  <= in_chan.valid;
      bv_r  <= av_r;
      cv_r  <= bv_r;
      dvv_r <= {dvv_r[QB-1:0], cv_r};
      ov_r  <= dvv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r.mode <= mode_t'(in_chan.mode);
      a_r.ar   <= in_chan.a_re;
      a_r.ai   <= in_chan.a_im;
      a_r.br   <= in_chan.b_re;
      a_r.bi   <= in_chan.b_im;
      b_r      <= b_nxt;
      c_r      <= c_nxt;
      for (int i = 0; i <= QB; i++) dv_r[i] <= dv_nxt[i];
      ore_r    <= ore_nxt;
      oim_r    <= oim_nxt;
      oflag_r  <= oflag_nxt;
      ostat_r  <= ostat_nxt;
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.result_re    = ore_r;
  assign out_chan.result_im    = oim_r;
  assign out_chan.compare_flag = oflag_r;
  assign out_chan.status       = ostat_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ostat_r == STATUS_DIV_ZERO |-> ore_r == '0 && oim_r == '0 && !oflag_r)
    else $error("divide by zero result not zero");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oflag_r |-> ore_r == '0 && oim_r == '0 && ostat_r == STATUS_OK)
    else $error("compare result carries data");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r |-> in_chan.ready)
    else $error("input stalled with empty output");

endmodule
`default_nettype wire
